### sv/lfs_pkg.sv
// Shared types, register codes and effect constants for the light effect sequencer.
`timescale 1ns / 1ps

package lfs_pkg;

    // Effect mode codes held in the effect_mode register.
    localparam logic [3:0] MODE_IDLE   = 4'd0;
    localparam logic [3:0] MODE_NIGHT  = 4'd1;
    localparam logic [3:0] MODE_DANCE  = 4'd2;
    localparam logic [3:0] MODE_PULSE  = 4'd3;
    localparam logic [3:0] MODE_SWEEP  = 4'd4;
    localparam logic [3:0] MODE_STROBE = 4'd5;
    localparam logic [3:0] MODE_WARM   = 4'd6;
    localparam logic [3:0] MODE_COOL   = 4'd7;
    localparam logic [3:0] MODE_BEACON = 4'd8;

    // Register index of effect_mode on the configuration port.
    localparam logic REG_EFFECT_MODE = 1'b0;

    // Hue stepping.
    localparam logic [9:0] HUE_FULL     = 10'd360;
    localparam logic [9:0] DANCE_STEP   = 10'd30;
    localparam logic [9:0] RAINBOW_STEP = 10'd2;

    // Breathing ramp, in hundredths.
    localparam logic [6:0] BREATH_LOW  = 7'd30;
    localparam logic [6:0] BREATH_HIGH = 7'd100;

    // Flash periods in ticks.
    localparam logic [1:0] FLASH_PERIOD = 2'd3;
    localparam logic [2:0] BLINK_PERIOD = 3'd5;

    // Opacity levels.
    localparam logic [7:0] OPA_FULL = 8'd255;
    localparam logic [7:0] OPA_DIM  = 8'd178;
    localparam logic [7:0] OPA_NONE = 8'd0;

    typedef logic [3:0] t_mode;

    // One color with its opacity.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
    } t_pixel;

    // What the color stage needs to render one frame, after the state update.
    typedef struct packed {
        t_mode      mode;
        logic [8:0] hue;
        logic [6:0] level;
        logic       lit;
    } t_desc;

endpackage

### sv/lfs_state.sv
// Effect state registers and their per-tick update.
`timescale 1ns / 1ps

module lfs_state
    import lfs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_mode i_mode,
    input  logic  i_step,
    output logic  o_emit,
    output t_desc o_desc
);

    logic [8:0] r_dance_hue, n_dance_hue;
    logic [8:0] r_rainbow_hue, n_rainbow_hue;
    logic [6:0] r_breath_level, n_breath_level;
    logic       r_breath_rising, n_breath_rising;
    logic [1:0] r_flash_count, n_flash_count;
    logic       r_flash_lit, n_flash_lit;
    logic [2:0] r_blink_count, n_blink_count;
    logic       r_blink_lit, n_blink_lit;

    logic [9:0] dance_sum;
    logic [9:0] rainbow_sum;
    logic [8:0] breath_sum;
    logic [1:0] flash_inc;
    logic [2:0] blink_inc;

    // Candidate next values for every effect; only the active one is kept.
    always_comb begin
        dance_sum   = {1'b0, r_dance_hue} + DANCE_STEP;
        rainbow_sum = {1'b0, r_rainbow_hue} + RAINBOW_STEP;
        breath_sum  = r_breath_rising ? ({2'b00, r_breath_level} + 9'd3)
                                      : ({2'b00, r_breath_level} - 9'd3);
        flash_inc   = r_flash_count + 2'd1;
        blink_inc   = r_blink_count + 3'd1;

        n_dance_hue     = r_dance_hue;
        n_rainbow_hue   = r_rainbow_hue;
        n_breath_level  = r_breath_level;
        n_breath_rising = r_breath_rising;
        n_flash_count   = r_flash_count;
        n_flash_lit     = r_flash_lit;
        n_blink_count   = r_blink_count;
        n_blink_lit     = r_blink_lit;

        if (i_step) begin
            case (i_mode)
                MODE_DANCE: begin
                    n_dance_hue = (dance_sum >= HUE_FULL) ? 9'd0 : dance_sum[8:0];
                end
                MODE_SWEEP: begin
                    n_rainbow_hue = (rainbow_sum >= HUE_FULL) ? 9'd0 : rainbow_sum[8:0];
                end
                MODE_PULSE: begin
                    // Bit 8 of the sum acts as a sign; a negative value falls into the low clamp.
                    if (!breath_sum[8] && breath_sum >= {2'b00, BREATH_HIGH}) begin
                        n_breath_level  = BREATH_HIGH;
                        n_breath_rising = 1'b0;
                    end else if (breath_sum[8] || breath_sum <= {2'b00, BREATH_LOW}) begin
                        n_breath_level  = BREATH_LOW;
                        n_breath_rising = 1'b1;
                    end else begin
                        n_breath_level = breath_sum[6:0];
                    end
                end
                MODE_STROBE: begin
                    if (flash_inc >= FLASH_PERIOD) begin
                        n_flash_count = 2'd0;
                        n_flash_lit   = ~r_flash_lit;
                    end else begin
                        n_flash_count = flash_inc;
                    end
                end
                MODE_BEACON: begin
                    if (blink_inc >= BLINK_PERIOD) begin
                        n_blink_count = 3'd0;
                        n_blink_lit   = ~r_blink_lit;
                    end else begin
                        n_blink_count = blink_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Descriptor of the frame, built from the updated state.
    always_comb begin
        o_emit       = i_step && (i_mode inside {[MODE_NIGHT:MODE_BEACON]});
        o_desc.mode  = i_mode;
        o_desc.hue   = (i_mode == MODE_DANCE) ? n_dance_hue : n_rainbow_hue;
        o_desc.level = n_breath_level;
        o_desc.lit   = (i_mode == MODE_STROBE) ? n_flash_lit : n_blink_lit;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dance_hue     <= 9'd0;
            r_rainbow_hue   <= 9'd0;
            r_breath_level  <= 7'd0;
            r_breath_rising <= 1'b1;
            r_flash_count   <= 2'd0;
            r_flash_lit     <= 1'b0;
            r_blink_count   <= 3'd0;
            r_blink_lit     <= 1'b0;
        end else begin
            r_dance_hue     <= n_dance_hue;
            r_rainbow_hue   <= n_rainbow_hue;
            r_breath_level  <= n_breath_level;
            r_breath_rising <= n_breath_rising;
            r_flash_count   <= n_flash_count;
            r_flash_lit     <= n_flash_lit;
            r_blink_count   <= n_blink_count;
            r_blink_lit     <= n_blink_lit;
        end
    end

endmodule

### sv/lfs_color.sv
// Color rendering: hue to RGB, breathing opacity and the fixed looks.
`timescale 1ns / 1ps

module lfs_color
    import lfs_pkg::*;
(
    input  t_desc  i_desc,
    output t_pixel o_pixel
);

    logic [2:0]  sector;
    logic [8:0]  base;
    logic [5:0]  frac;
    logic [6:0]  tri_val;
    logic [10:0] x_scaled;
    logic [7:0]  x;
    logic [24:0] opa_prod;
    logic [7:0]  breath_opa;

    // Hue sector by threshold compares, then the ramp within the sector.
    always_comb begin
        if (i_desc.hue >= 9'd300) begin
            sector = 3'd5;
            base   = 9'd300;
        end else if (i_desc.hue >= 9'd240) begin
            sector = 3'd4;
            base   = 9'd240;
        end else if (i_desc.hue >= 9'd180) begin
            sector = 3'd3;
            base   = 9'd180;
        end else if (i_desc.hue >= 9'd120) begin
            sector = 3'd2;
            base   = 9'd120;
        end else if (i_desc.hue >= 9'd60) begin
            sector = 3'd1;
            base   = 9'd60;
        end else begin
            sector = 3'd0;
            base   = 9'd0;
        end
        frac    = 6'(i_desc.hue - base);
        tri_val = sector[0] ? (7'd60 - {1'b0, frac}) : {1'b0, frac};
        // floor(t*255/60) equals floor(t*17/4).
        x_scaled = {tri_val, 4'b0000} + {4'b0000, tri_val};
        x        = x_scaled[9:2];
    end

    // floor(level*255/100) through a reciprocal; exact for every level from 0 to 100.
    always_comb begin
        opa_prod   = 25'(i_desc.level) * 25'd167127;
        breath_opa = opa_prod[23:16];
    end

    // Look selection by mode.
    always_comb begin
        o_pixel = '{red: 8'd0, green: 8'd0, blue: 8'd0, opacity: OPA_NONE};
        case (i_desc.mode)
            MODE_NIGHT: begin
                o_pixel = '{red: 8'd255, green: 8'd255, blue: 8'd255, opacity: OPA_FULL};
            end
            MODE_WARM: begin
                o_pixel = '{red: 8'd255, green: 8'd200, blue: 8'd120, opacity: OPA_FULL};
            end
            MODE_COOL: begin
                o_pixel = '{red: 8'd180, green: 8'd220, blue: 8'd255, opacity: OPA_FULL};
            end
            MODE_PULSE: begin
                o_pixel = '{red: 8'd80, green: 8'd120, blue: 8'd255, opacity: breath_opa};
            end
            MODE_STROBE: begin
                if (i_desc.lit) begin
                    o_pixel = '{red: 8'd255, green: 8'd255, blue: 8'd255, opacity: OPA_FULL};
                end
            end
            MODE_BEACON: begin
                if (i_desc.lit) begin
                    o_pixel = '{red: 8'd0, green: 8'd100, blue: 8'd255, opacity: OPA_FULL};
                end else begin
                    o_pixel = '{red: 8'd0, green: 8'd30, blue: 8'd80, opacity: OPA_DIM};
                end
            end
            MODE_DANCE, MODE_SWEEP: begin
                o_pixel.opacity = OPA_FULL;
                case (sector)
                    3'd0: begin
                        o_pixel.red = 8'd255; o_pixel.green = x;      o_pixel.blue = 8'd0;
                    end
                    3'd1: begin
                        o_pixel.red = x;      o_pixel.green = 8'd255; o_pixel.blue = 8'd0;
                    end
                    3'd2: begin
                        o_pixel.red = 8'd0;   o_pixel.green = 8'd255; o_pixel.blue = x;
                    end
                    3'd3: begin
                        o_pixel.red = 8'd0;   o_pixel.green = x;      o_pixel.blue = 8'd255;
                    end
                    3'd4: begin
                        o_pixel.red = x;      o_pixel.green = 8'd0;   o_pixel.blue = 8'd255;
                    end
                    default: begin
                        o_pixel.red = 8'd255; o_pixel.green = 8'd0;   o_pixel.blue = x;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

### sv/light_effect_sequencer.sv
// Top level of the light effect sequencer: config port, frame register and result register.
`timescale 1ns / 1ps

// The sequencer accepts one tick beat per clock cycle while o_ready is high. The effect
// state is updated in the cycle of acceptance, which sets that rate; the descriptor is
// held in the frame register and the color in the result register. A tick of zero, or
// a tick in off mode or an unused mode code, yields no result. The result register and
// the frame register between them let a new tick be taken while a finished color waits;
// with both full, the input stalls until the result beat is taken. effect_mode sits at
// byte address 0 of the configuration port; the user must write it only while the block
// is idle, which the block itself does not enforce. Reset needs no clearing pass.
module light_effect_sequencer
    import lfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Tick channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_tick,
    // Color channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_opacity
);

    t_mode  r_mode;
    logic   r_s1_valid, n_s1_valid;
    t_desc  r_s1_desc;
    logic   r_out_valid, n_out_valid;
    t_pixel r_out_pixel;

    logic   cfg_write;
    logic   in_accept;
    logic   out_load;
    logic   emit;
    t_desc  desc;
    t_pixel pixel;

    // Configuration access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_EFFECT_MODE) ? {28'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else if (cfg_write && paddr[2] == REG_EFFECT_MODE) begin
            r_mode <= pwdata[3:0];
        end
    end

    // Handshake: the result register loads when empty or being drained.
    assign out_load  = !r_out_valid || i_ready;
    assign o_ready   = !r_s1_valid || out_load;
    assign in_accept = i_valid && o_ready;

    lfs_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_step  (in_accept && i_tick),
        .o_emit  (emit),
        .o_desc  (desc)
    );

    lfs_color u_color (
        .i_desc  (r_s1_desc),
        .o_pixel (pixel)
    );

    // Valid bits of the frame and result registers.
    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = r_s1_valid;
            n_s1_valid  = 1'b0;
        end
        if (in_accept) begin
            n_s1_valid = emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept && emit) begin
            r_s1_desc <= desc;
        end
        if (out_load && r_s1_valid) begin
            r_out_pixel <= pixel;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_red     = r_out_pixel.red;
    assign o_green   = r_out_pixel.green;
    assign o_blue    = r_out_pixel.blue;
    assign o_opacity = r_out_pixel.opacity;

endmodule

### sv/lfs_checker.sv
// Port-level checks for the light effect sequencer and their binding to the top level.
`timescale 1ns / 1ps

module lfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic [7:0]  o_opacity
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

    // A stalled result beat is held.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    // Only the dark flash look is transparent, and it is black.
    a_dark_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_opacity == 8'd0 |-> o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0)
        else $error("transparent result with a color");

    // Partial opacity other than the dim blue flash comes only from breathing.
    a_breath_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_opacity != 8'd0 && o_opacity != 8'd255 && o_opacity != 8'd178
        |-> o_red == 8'd80 && o_green == 8'd120 && o_blue == 8'd255)
        else $error("partial opacity with a color other than the breathing blue");

    // The dim blue flash look carries its own color.
    a_dim_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_opacity == 8'd178 && o_red != 8'd80
        |-> o_red == 8'd0 && o_green == 8'd30 && o_blue == 8'd80)
        else $error("dim opacity with a wrong color");

endmodule

bind light_effect_sequencer lfs_checker u_lfs_checker (.*);
